@@ rtl/sle_pkg.sv @@
// shared types, codes and decode helpers for the string literal unescaper
package sle_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_OK         = 2'd1;
  localparam logic [1:0] KIND_BAD_UTF8   = 2'd2;
  localparam logic [1:0] KIND_BAD_ESCAPE = 2'd3;

  // sticky error codes share the kind encoding
  localparam logic [1:0] ERR_NONE = 2'd0;

  // range checks for the first continuation byte
  localparam logic [2:0] CHK_ANY     = 3'd0;  // 80..bf
  localparam logic [2:0] CHK_A0_BF   = 3'd1;  // after e0
  localparam logic [2:0] CHK_80_9F   = 3'd2;  // after ed
  localparam logic [2:0] CHK_90_BF   = 3'd3;  // after f0
  localparam logic [2:0] CHK_80_8F   = 3'd4;  // after f4

  localparam logic [7:0] BACKSLASH = 8'h5C;

  localparam int NUM_SLOTS = 5;
  localparam int NUM_DATA  = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_literal;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       final_result;
  } out_item_t;

  // the results caused by one input item, in order
  typedef struct packed {
    out_item_t [NUM_SLOTS-1:0] slot;
    logic [2:0]                count;
  } sle_group_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_map_t;

  function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] chk);
    logic ok;
    case (chk)
      CHK_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
      CHK_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
      CHK_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
      CHK_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
      default:   ok = (b >= 8'h80) && (b <= 8'hBF);
    endcase
    return ok;
  endfunction

  function automatic esc_map_t escape_map(input logic [7:0] c);
    esc_map_t m;
    m.hit = 1'b1;
    case (c)
      8'h5C:   m.value = 8'h5C;
      8'h74:   m.value = 8'h09;
      8'h6E:   m.value = 8'h0A;
      8'h76:   m.value = 8'h0B;
      8'h66:   m.value = 8'h0C;
      8'h72:   m.value = 8'h0D;
      8'h30:   m.value = 8'h00;
      8'h22:   m.value = 8'h22;
      default: begin
        m.hit   = 1'b0;
        m.value = 8'h00;
      end
    endcase
    return m;
  endfunction

endpackage

@@ rtl/string_literal_unescape_core.sv @@
// String literal unescaper with UTF-8 checking, top level.
// The input channel takes one byte of a literal body per item (in_data), with
// byte_present low for an end-only or idle item and end_of_literal high on the
// item that closes the literal. The result channel gives each item's results in
// order, none to five of them: decoded data bytes (kind data) and, for the
// closing item, one status result with final_result high and kind ok, invalid
// UTF-8 or invalid escape.
// A codepoint's bytes come out together once its last byte arrives; an escape
// pair gives a single byte. After an error, bytes are dropped until the close.
// The first result of an item is registered in the result buffer and appears in
// the cycle after the item is accepted. While out_stall is low, one input item
// is taken per cycle if each item makes at most one result, and the buffer
// drains one result per cycle; an item with more (up to five) holds the input.
// in_stall goes low as soon as the last buffered result is being taken.
// Reset (rst_n low, synchronous) empties the result buffer and returns the
// decoder to the start of a literal. When out_stall is high the current
// result holds steady and new items are refused once the buffer is busy.
module string_literal_unescape_core import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       ready;
  logic       accept;
  sle_group_t group;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  sle_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .group  (group)
  );

  sle_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .group     (group),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/sle_decode.sv @@
// utf-8 and escape decoder: per-literal state and the result group of one item
module sle_decode import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  output sle_group_t group
);

  logic [1:0] cont_left_r, cont_left_nxt;
  logic [1:0] held_r, held_nxt;
  logic [2:0] sbc_r, sbc_nxt;
  logic       esc_r, esc_nxt;
  logic [1:0] err_r, err_nxt;
  logic [7:0] cp_bytes_r [3];
  logic [7:0] cp_bytes_nxt [3];

  logic [7:0] b;
  logic       take;
  logic       do_cmp;
  logic [2:0] chk;
  logic [1:0] held_eff;
  logic [1:0] err_fin;
  esc_map_t   em;
  logic [7:0] d [NUM_DATA];
  logic [2:0] n_data;
  logic       status;
  logic [1:0] status_kind;

  always_comb begin
    cont_left_nxt = cont_left_r;
    held_nxt      = held_r;
    sbc_nxt       = sbc_r;
    esc_nxt       = esc_r;
    err_nxt       = err_r;
    cp_bytes_nxt  = cp_bytes_r;
    b             = item.in_byte;
    take          = accept && item.byte_present && (err_r == ERR_NONE);
    do_cmp        = 1'b0;
    chk           = (held_r == 2'd1) ? sbc_r : CHK_ANY;
    held_eff      = (cont_left_r == 2'd0) ? 2'd0 : held_r;
    em            = escape_map(b);
    n_data        = 3'd0;
    status        = 1'b0;
    status_kind   = KIND_OK;
    err_fin       = ERR_NONE;
    for (int i = 0; i < NUM_DATA; i++) begin
      d[i] = 8'h00;
    end

    if (take) begin
      if (cont_left_r != 2'd0) begin
        if (!cont_ok(b, chk) || (held_r == 2'd0)) begin
          err_nxt = KIND_BAD_UTF8;
        end else begin
          cont_left_nxt = cont_left_r - 2'd1;
          if (cont_left_r == 2'd1) begin
            do_cmp = 1'b1;
          end else begin
            case (held_r)
              2'd1:    cp_bytes_nxt[1] = b;
              2'd2:    cp_bytes_nxt[2] = b;
              default: ;
            endcase
            held_nxt = held_r + 2'd1;
          end
        end
      end else if (b < 8'h80) begin
        do_cmp = 1'b1;
      end else if ((b < 8'hC2) || (b > 8'hF4)) begin
        err_nxt = KIND_BAD_UTF8;
      end else begin
        if (b < 8'hE0) begin
          cont_left_nxt = 2'd1;
          sbc_nxt       = CHK_ANY;
        end else if (b < 8'hF0) begin
          cont_left_nxt = 2'd2;
          sbc_nxt       = (b == 8'hE0) ? CHK_A0_BF : ((b == 8'hED) ? CHK_80_9F : CHK_ANY);
        end else begin
          cont_left_nxt = 2'd3;
          sbc_nxt       = (b == 8'hF0) ? CHK_90_BF : ((b == 8'hF4) ? CHK_80_8F : CHK_ANY);
        end
        cp_bytes_nxt[0] = b;
        held_nxt        = 2'd1;
      end
    end

    // codepoint finished with byte b
    if (do_cmp) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if ((held_eff == 2'd0) && em.hit) begin
          d[0]   = em.value;
          n_data = 3'd1;
        end else begin
          err_nxt = KIND_BAD_ESCAPE;
        end
      end else if ((held_eff == 2'd0) && (b == BACKSLASH)) begin
        esc_nxt = 1'b1;
      end else begin
        d[0]   = (held_eff > 2'd0) ? cp_bytes_r[0] : b;
        d[1]   = (held_eff > 2'd1) ? cp_bytes_r[1] : b;
        d[2]   = (held_eff > 2'd2) ? cp_bytes_r[2] : b;
        d[3]   = b;
        n_data = {1'b0, held_eff} + 3'd1;
      end
      held_nxt      = 2'd0;
      cont_left_nxt = 2'd0;
      sbc_nxt       = CHK_ANY;
    end

    // closing item: status result and back to the idle state
    if (accept && item.end_of_literal) begin
      err_fin = err_nxt;
      if ((err_nxt == ERR_NONE) && (cont_left_nxt != 2'd0)) begin
        err_fin = KIND_BAD_UTF8;
      end
      status        = 1'b1;
      status_kind   = (err_fin == ERR_NONE) ? KIND_OK : err_fin;
      cont_left_nxt = 2'd0;
      held_nxt      = 2'd0;
      sbc_nxt       = CHK_ANY;
      esc_nxt       = 1'b0;
      err_nxt       = ERR_NONE;
    end
  end

  // pack data results first, the status result right after them
  always_comb begin
    for (int i = 0; i < NUM_DATA; i++) begin
      if (3'(i) < n_data) begin
        group.slot[i] = '{out_byte: d[i], kind: KIND_DATA, final_result: 1'b0};
      end else begin
        group.slot[i] = '{out_byte: 8'h00, kind: status_kind, final_result: 1'b1};
      end
    end
    group.slot[NUM_SLOTS-1] = '{out_byte: 8'h00, kind: status_kind, final_result: 1'b1};
    group.count = n_data + {2'b00, status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_left_r <= 2'd0;
      held_r      <= 2'd0;
      sbc_r       <= CHK_ANY;
      esc_r       <= 1'b0;
      err_r       <= ERR_NONE;
    end else if (accept) begin
      cont_left_r <= cont_left_nxt;
      held_r      <= held_nxt;
      sbc_r       <= sbc_nxt;
      esc_r       <= esc_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cp_bytes_r <= cp_bytes_nxt;
    end
  end

`ifndef SYNTHESIS
  a_held_tracks_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (cont_left_r != 2'd0) == (held_r != 2'd0))
    else $error("held byte count and continuation count disagree");

  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, held_r} + {1'b0, cont_left_r}) <= 3'd4)
    else $error("codepoint longer than four bytes");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != KIND_OK)
    else $error("status code stored as an error");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.end_of_literal |=> (err_r == ERR_NONE) && !esc_r && (held_r == 2'd0))
    else $error("state not cleared after closing item");
`endif

endmodule

@@ rtl/sle_out_buf.sv @@
// result buffer: holds one item's result group and hands the results out in order
module sle_out_buf import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  sle_group_t group,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  out_item_t [NUM_SLOTS-1:0] slots_r;
  out_item_t [NUM_SLOTS-1:0] slots_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      take;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = slots_r[0];
  assign take      = out_valid && !out_stall;
  // a new group fits once the last buffered result leaves
  assign ready     = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall);

  always_comb begin
    slots_nxt = slots_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slots_nxt = group.slot;
      cnt_nxt   = group.count;
    end else if (take) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        slots_nxt[i] = slots_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(NUM_SLOTS))
    else $error("result count out of range");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.final_result |-> cnt_r == 3'd1)
    else $error("status result is not the last of its group");

  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.final_result == (out_data.kind != KIND_DATA))
    else $error("final flag and kind disagree");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 3'd0) || ((cnt_r == 3'd1) && take))
    else $error("group loaded over pending results");
`endif

endmodule

@@ tb/sle_decode_checker.sv @@
// watches both channels of the string literal unescaper, predicts its results and compares them
module sle_decode_checker import sle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // decoder state as the block should hold it
  logic [1:0] cont_left        = 2'd0;
  logic [7:0] lead_bytes [3];
  logic [1:0] lead_count       = 2'd0;
  logic [2:0] first_cont_range = CHK_ANY;
  logic       escape_open      = 1'b0;
  logic [1:0] sticky_err       = ERR_NONE;

  out_item_t   decoded_q [$];
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 60) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void clear_literal();
    cont_left        = 2'd0;
    lead_count       = 2'd0;
    first_cont_range = CHK_ANY;
    escape_open      = 1'b0;
    sticky_err       = ERR_NONE;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic [1:0] k,
                                      input logic fin);
    out_item_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.final_result = fin;
    decoded_q.push_back(r);
  endfunction

  function automatic logic fits_range(input logic [7:0] b, input logic [2:0] rng);
    case (rng)
      CHK_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
      CHK_80_9F: return b >= 8'h80 && b <= 8'h9F;
      CHK_90_BF: return b >= 8'h90 && b <= 8'hBF;
      CHK_80_8F: return b >= 8'h80 && b <= 8'h8F;
      default:   return b >= 8'h80 && b <= 8'hBF;
    endcase
  endfunction

  // byte that an escape letter stands for, or -1 when the pair is not an escape
  function automatic int escape_value(input logic [7:0] c);
    case (c)
      BACKSLASH: return 8'h5C;
      "t":       return 8'h09;
      "n":       return 8'h0A;
      "v":       return 8'h0B;
      "f":       return 8'h0C;
      "r":       return 8'h0D;
      "0":       return 8'h00;
      8'h22:     return 8'h22;
      default:   return -1;
    endcase
  endfunction

  // last byte of a codepoint has arrived
  function automatic void finish_codepoint(input logic [7:0] b);
    int v;
    if (escape_open) begin
      escape_open = 1'b0;
      v = (lead_count == 2'd0) ? escape_value(b) : -1;
      if (v < 0) sticky_err = KIND_BAD_ESCAPE;
      else push_result(8'(v), KIND_DATA, 1'b0);
    end else if (lead_count == 2'd0 && b == BACKSLASH) begin
      escape_open = 1'b1;
    end else begin
      for (int i = 0; i < int'(lead_count); i++) push_result(lead_bytes[i], KIND_DATA, 1'b0);
      push_result(b, KIND_DATA, 1'b0);
    end
    lead_count       = 2'd0;
    cont_left        = 2'd0;
    first_cont_range = CHK_ANY;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [2:0] rng;
    if (cont_left != 2'd0) begin
      rng = (lead_count == 2'd1) ? first_cont_range : CHK_ANY;
      if (!fits_range(b, rng) || lead_count == 2'd0) begin
        sticky_err = KIND_BAD_UTF8;
        return;
      end
      cont_left--;
      if (cont_left == 2'd0) begin
        finish_codepoint(b);
      end else begin
        lead_bytes[lead_count] = b;
        lead_count++;
      end
      return;
    end
    if (b < 8'h80) begin
      lead_count = 2'd0;
      finish_codepoint(b);
      return;
    end
    if (b < 8'hC2 || b > 8'hF4) begin
      sticky_err = KIND_BAD_UTF8;
      return;
    end
    if (b < 8'hE0) begin
      cont_left        = 2'd1;
      first_cont_range = CHK_ANY;
    end else if (b < 8'hF0) begin
      cont_left        = 2'd2;
      first_cont_range = (b == 8'hE0) ? CHK_A0_BF : (b == 8'hED) ? CHK_80_9F : CHK_ANY;
    end else begin
      cont_left        = 2'd3;
      first_cont_range = (b == 8'hF0) ? CHK_90_BF : (b == 8'hF4) ? CHK_80_8F : CHK_ANY;
    end
    lead_bytes[0] = b;
    lead_count    = 2'd1;
  endfunction

  function automatic void decode_item(input in_item_t it);
    logic [1:0] k;
    if (it.byte_present && sticky_err == ERR_NONE) take_byte(it.in_byte);
    if (it.end_of_literal) begin
      // a codepoint cut off by the end counts as bad utf-8, a lone backslash is dropped
      if (sticky_err == ERR_NONE && cont_left != 2'd0) sticky_err = KIND_BAD_UTF8;
      k = (sticky_err == ERR_NONE) ? KIND_OK : sticky_err;
      push_result(8'h00, k, 1'b1);
      clear_literal();
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_literal();
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_item(in_data);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %h kind %0d final %0b",
                                    out_data.out_byte, out_data.kind, out_data.final_result));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte,
                                      want.out_byte));
          if (out_data.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
          if (out_data.final_result !== want.final_result)
            report_mismatch($sformatf("final_result %0b, want %0b", out_data.final_result,
                                      want.final_result));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= decoded_q.size();
  end

endmodule

@@ tb/string_literal_unescape_core_test.sv @@
// stimulus and verdict for the string literal unescaper, with the checker beside the block
module string_literal_unescape_core_test;
  import sle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 420;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  logic [7:0]  lit_bytes [$];

  string_literal_unescape_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sle_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall   <= ($urandom_range(99) < stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid only drops when the sender decides to idle, never between back-to-back items
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.byte_present || it.end_of_literal) items_sent++;
  endtask

  task automatic send_idle_item();
    in_item_t it;
    it.in_byte        = 8'($urandom_range(255));
    it.byte_present   = 1'b0;
    it.end_of_literal = 1'b0;
    send_item(it);
  endtask

  task automatic send_literal(input logic merge_end);
    in_item_t it;
    logic     fold;
    fold = merge_end && lit_bytes.size() != 0;
    foreach (lit_bytes[i]) begin
      if ($urandom_range(19) == 0) send_idle_item();
      it.in_byte        = lit_bytes[i];
      it.byte_present   = 1'b1;
      it.end_of_literal = fold && (i == lit_bytes.size() - 1);
      send_item(it);
    end
    if (!fold) begin
      // end-only item, its byte field must be ignored
      it.in_byte        = 8'($urandom_range(255));
      it.byte_present   = 1'b0;
      it.end_of_literal = 1'b1;
      send_item(it);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(127)); while (c == BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(7))
      0:       return BACKSLASH;
      1:       return "t";
      2:       return "n";
      3:       return "v";
      4:       return "f";
      5:       return "r";
      6:       return "0";
      default: return 8'h22;
    endcase
  endfunction

  // a codepoint of two to four bytes, well formed but for a random continuation byte now and then
  function automatic void add_multibyte();
    int         len;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    len = $urandom_range(4, 2);
    if (len == 2) begin
      lead = 8'($urandom_range(8'hDF, 8'hC2));
    end else if (len == 3) begin
      case ($urandom_range(3))
        0:       lead = 8'hE0;
        1:       lead = 8'hED;
        default: lead = 8'($urandom_range(8'hEF, 8'hE0));
      endcase
    end else begin
      case ($urandom_range(3))
        0:       lead = 8'hF0;
        1:       lead = 8'hF4;
        default: lead = 8'($urandom_range(8'hF4, 8'hF0));
      endcase
    end
    lo = (lead == 8'hE0) ? 8'hA0 : (lead == 8'hF0) ? 8'h90 : 8'h80;
    hi = (lead == 8'hED) ? 8'h9F : (lead == 8'hF4) ? 8'h8F : 8'hBF;
    lit_bytes.push_back(lead);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(19) == 0) lit_bytes.push_back(8'($urandom_range(255)));
      else lit_bytes.push_back(8'($urandom_range(hi, lo)));
      lo = 8'h80;
      hi = 8'hBF;
    end
  endfunction

  function automatic void build_literal();
    int n_tok;
    int pick;
    lit_bytes.delete();
    n_tok = $urandom_range(8);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        lit_bytes.push_back(plain_char());
      end else if (pick < 58) begin
        lit_bytes.push_back(BACKSLASH);
        lit_bytes.push_back(escape_letter());
      end else if (pick < 86) begin
        add_multibyte();
      end else if (pick < 93) begin
        lit_bytes.push_back(8'($urandom_range(255)));
      end else begin
        // mostly a bad escape, sometimes a multi-byte partner
        lit_bytes.push_back(BACKSLASH);
        if ($urandom_range(3) == 0) add_multibyte();
        else lit_bytes.push_back(plain_char());
      end
    end
    pick = $urandom_range(99);
    if (pick < 5) lit_bytes.push_back(BACKSLASH);
    else if (pick < 10) lit_bytes.push_back(8'($urandom_range(8'hF4, 8'hC2)));
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // escapes including a zero byte
    lit_bytes = '{8'h5C, 8'h30, 8'h5C, 8'h5C};
    send_literal(1'b1);
    // four-byte maximum codepoint closing on the same item gives five results
    lit_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_literal(1'b1);
    // idle item, then a byte that can never appear, later bytes dropped
    send_idle_item();
    lit_bytes = '{8'hFF, 8'h41};
    send_literal(1'b1);
    // backslash followed by a multi-byte codepoint
    lit_bytes = '{8'h5C, 8'hE2, 8'h82, 8'hAC};
    send_literal(1'b0);
    // broken utf-8 right after a backslash
    lit_bytes = '{8'h5C, 8'hC0};
    send_literal(1'b1);
    // codepoint cut off by the end
    lit_bytes = '{8'hE2, 8'h82};
    send_literal(1'b1);
    // lone backslash at the end
    lit_bytes = '{8'h41, 8'h5C};
    send_literal(1'b1);
    // empty literal
    lit_bytes.delete();
    send_literal(1'b0);
    lit_bytes = '{8'h5C, 8'h71};
    send_literal(1'b1);
    wait_for_results();

    items_sent = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 61;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 61;
        end
        default: begin
          idle_pct  = 34;
          stall_pct <= 34;
        end
      endcase
      while (items_sent < (p + 1) * RANDOM_ITEMS / 4) begin
        build_literal();
        send_literal(1'($urandom_range(1)));
      end
      wait_for_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
